FILE: src/cbrs_pkg.sv
// Package for the credit bucket: payload, command, profile and register types.
// Shared limits of the bucket arithmetic. No dependencies.
package cbrs_pkg;

  localparam logic [15:0] MANA_LIMIT    = 16'd65535;
  localparam logic [9:0]  RATE_LIMIT    = 10'd1023;
  localparam logic [31:0] OFFLINE_LIMIT = 32'd604800;

  // Any elapsed time of 65535 s or more already fills any reserve whose rate is nonzero,
  // so the multiplier only needs the smaller of the offline limit and that bound.
  localparam logic [15:0] ELAPSED_CAP =
      (OFFLINE_LIMIT > 32'd65535) ? 16'hFFFF : OFFLINE_LIMIT[15:0];

  localparam int unsigned PADDR_W = 5;

  typedef enum logic [1:0] {
    ACT_CREATE  = 2'd0,
    ACT_PROJECT = 2'd1,
    ACT_SPEND   = 2'd2
  } cbrs_action_e;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_PROJECT = 2'd1,
    OP_SPEND   = 2'd2,
    OP_IGNORE  = 2'd3
  } cbrs_op_e;

  typedef enum logic [2:0] {
    REG_PROF_ID       = 3'd0,
    REG_PROF_REVISION = 3'd1,
    REG_PROF_CAPACITY = 3'd2,
    REG_PROF_RATE     = 3'd3,
    REG_PROF_FLOOR    = 3'd4
  } cbrs_reg_e;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] now;
    logic [31:0] new_uid;
    logic [15:0] cost;
    logic        passive;
  } cbrs_in_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] reserve_out;
    logic [31:0] version_out;
  } cbrs_out_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] revision;
    logic [15:0] capacity;
    logic [9:0]  rate;
    logic [15:0] floor;
  } cbrs_prof_t;

  typedef struct packed {
    cbrs_op_e    op;
    logic [31:0] now;
    logic [31:0] uid;
    logic [15:0] cost;
    logic        passive;
    logic        cost_ok;
    logic        create_ok;
    logic        prof_ok;
  } cbrs_cmd_t;

endpackage

FILE: src/cbrs_regs.sv
// Profile configuration registers behind an APB-style port.
// Depends on cbrs_pkg for the profile struct and register indexes.
module cbrs_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cbrs_pkg::PADDR_W-1:0]      paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output cbrs_pkg::cbrs_prof_t              prof_o
);

  cbrs_pkg::cbrs_prof_t prof_q, prof_d;
  logic                 wr_en;
  logic [2:0]           reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];

  always_comb begin
    prof_d = prof_q;
    if (wr_en) begin
      case (reg_idx)
        cbrs_pkg::REG_PROF_ID:       prof_d.id       = pwdata;
        cbrs_pkg::REG_PROF_REVISION: prof_d.revision = pwdata;
        cbrs_pkg::REG_PROF_CAPACITY: prof_d.capacity = pwdata[15:0];
        cbrs_pkg::REG_PROF_RATE:     prof_d.rate     = pwdata[9:0];
        cbrs_pkg::REG_PROF_FLOOR:    prof_d.floor    = pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      cbrs_pkg::REG_PROF_ID:       prdata = prof_q.id;
      cbrs_pkg::REG_PROF_REVISION: prdata = prof_q.revision;
      cbrs_pkg::REG_PROF_CAPACITY: prdata = {16'b0, prof_q.capacity};
      cbrs_pkg::REG_PROF_RATE:     prdata = {22'b0, prof_q.rate};
      cbrs_pkg::REG_PROF_FLOOR:    prdata = {16'b0, prof_q.floor};
      default:                     prdata = 32'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prof_q <= '0;
    end else begin
      prof_q <= prof_d;
    end
  end

  assign prof_o = prof_q;

endmodule

FILE: src/cbrs_front.sv
// Front end: accepts requests and classifies them into queue commands.
// Checks that need no record state (uid, cost, profile) are done here. Uses cbrs_pkg.
module cbrs_front (
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  cbrs_pkg::cbrs_in_t    in_data_i,
  input  cbrs_pkg::cbrs_prof_t  prof_i,
  output logic                  q_valid_o,
  input  logic                  q_ready_i,
  output cbrs_pkg::cbrs_cmd_t   q_cmd_o
);

  logic prof_ok;

  assign prof_ok = (prof_i.id != 32'd0) && (prof_i.revision != 32'd0) &&
                   (prof_i.capacity != 16'd0) && (prof_i.capacity <= cbrs_pkg::MANA_LIMIT) &&
                   (prof_i.rate <= cbrs_pkg::RATE_LIMIT) && (prof_i.floor <= prof_i.capacity);

  always_comb begin
    q_cmd_o.now       = in_data_i.now;
    q_cmd_o.uid       = in_data_i.new_uid;
    q_cmd_o.cost      = in_data_i.cost;
    q_cmd_o.passive   = in_data_i.passive;
    q_cmd_o.prof_ok   = prof_ok;
    q_cmd_o.cost_ok   = (in_data_i.cost != 16'd0) && (in_data_i.cost <= cbrs_pkg::MANA_LIMIT);
    q_cmd_o.create_ok = (in_data_i.new_uid != 32'd0) && prof_ok;
    case (in_data_i.action)
      cbrs_pkg::ACT_CREATE:  q_cmd_o.op = cbrs_pkg::OP_CREATE;
      cbrs_pkg::ACT_PROJECT: q_cmd_o.op = cbrs_pkg::OP_PROJECT;
      cbrs_pkg::ACT_SPEND:   q_cmd_o.op = cbrs_pkg::OP_SPEND;
      default:               q_cmd_o.op = cbrs_pkg::OP_IGNORE;
    endcase
  end

  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;

endmodule

FILE: src/cbrs_fifo.sv
// Two-entry command queue between the front end and the record unit.
// Depends on cbrs_pkg for the command type.
module cbrs_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_valid_i,
  output logic                 push_ready_o,
  input  cbrs_pkg::cbrs_cmd_t  push_cmd_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output cbrs_pkg::cbrs_cmd_t  pop_cmd_o
);

  localparam int unsigned Depth = 2;

  cbrs_pkg::cbrs_cmd_t mem_q [Depth];
  logic                wr_ptr_q, wr_ptr_d;
  logic                rd_ptr_q, rd_ptr_d;
  logic [1:0]          count_q, count_d;
  logic                push, pop;

  assign push_ready_o = (count_q != 2'(Depth));
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_cmd_o    = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 2'(Depth))
    else $error("queue count above depth");

  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'(Depth)) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count did not grow on push");

endmodule

FILE: src/cbrs_back.sv
// Record unit: holds the credit record, applies create, project and spend,
// and registers one result per command. Depends on cbrs_pkg.
module cbrs_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cbrs_pkg::cbrs_prof_t  prof_i,
  input  logic                  q_valid_i,
  output logic                  q_ready_o,
  input  cbrs_pkg::cbrs_cmd_t   q_cmd_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output cbrs_pkg::cbrs_out_t   out_data_o
);

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] prof_id;
    logic [31:0] revision;
    logic [31:0] version;
    logic [15:0] capacity;
    logic [9:0]  rate;
    logic [15:0] reserve;
    logic [31:0] settled;
  } rec_t;

  rec_t                 rec_q, rec_d, proj;
  cbrs_pkg::cbrs_out_t  out_q, out_d;
  logic                 out_valid_q, out_valid_d;
  logic                 pop;
  logic                 rec_ok, proj_ok, spend_ok, ok;
  logic                 later;
  logic [31:0]          diff;
  logic [15:0]          elapsed;
  logic [25:0]          gain;
  logic [15:0]          room, gain_c, res_sum, res_p;

  assign pop       = q_valid_i & (~out_valid_q | out_ready_i);
  assign q_ready_o = ~out_valid_q | out_ready_i;

  always_comb begin
    rec_ok = (rec_q.uid != 32'd0) && (rec_q.prof_id != 32'd0) &&
             (rec_q.revision != 32'd0) && (rec_q.version != 32'd0) &&
             (rec_q.capacity != 16'd0) && (rec_q.capacity <= cbrs_pkg::MANA_LIMIT) &&
             (rec_q.rate <= cbrs_pkg::RATE_LIMIT) && (rec_q.reserve <= rec_q.capacity);
    proj_ok = rec_ok && q_cmd_i.prof_ok && (rec_q.prof_id == prof_i.id) &&
              !(prof_i.revision < rec_q.revision) &&
              !((prof_i.revision == rec_q.revision) &&
                ((rec_q.capacity != prof_i.capacity) || (rec_q.rate != prof_i.rate)));

    // Time that runs backwards regains nothing and keeps the settle time.
    later = q_cmd_i.now > rec_q.settled;
    diff  = q_cmd_i.now - rec_q.settled;
    if (!later) begin
      elapsed = 16'd0;
    end else if (diff > {16'b0, cbrs_pkg::ELAPSED_CAP}) begin
      elapsed = cbrs_pkg::ELAPSED_CAP;
    end else begin
      elapsed = diff[15:0];
    end
    gain    = {10'b0, elapsed} * {16'b0, rec_q.rate};
    room    = rec_q.capacity - rec_q.reserve;
    gain_c  = (gain > {10'b0, room}) ? room : gain[15:0];
    res_sum = rec_q.reserve + gain_c;
    res_p   = (res_sum > prof_i.capacity) ? prof_i.capacity : res_sum;

    proj          = rec_q;
    proj.reserve  = res_p;
    proj.settled  = later ? q_cmd_i.now : rec_q.settled;
    proj.capacity = prof_i.capacity;
    proj.rate     = prof_i.rate;
    proj.revision = prof_i.revision;

    spend_ok = q_cmd_i.cost_ok && (rec_q.version != '1) && proj_ok &&
               (q_cmd_i.cost <= res_p) &&
               !(q_cmd_i.passive && ((res_p - q_cmd_i.cost) < prof_i.floor));

    rec_d = rec_q;
    ok    = 1'b0;
    case (q_cmd_i.op)
      cbrs_pkg::OP_CREATE: begin
        rec_d = '0;
        if (q_cmd_i.create_ok) begin
          rec_d.uid      = q_cmd_i.uid;
          rec_d.prof_id  = prof_i.id;
          rec_d.revision = prof_i.revision;
          rec_d.version  = 32'd1;
          rec_d.capacity = prof_i.capacity;
          rec_d.rate     = prof_i.rate;
          rec_d.settled  = q_cmd_i.now;
          ok             = 1'b1;
        end
      end
      cbrs_pkg::OP_PROJECT: begin
        if (proj_ok) begin
          rec_d = proj;
          ok    = 1'b1;
        end
      end
      cbrs_pkg::OP_SPEND: begin
        if (spend_ok) begin
          rec_d         = proj;
          rec_d.reserve = res_p - q_cmd_i.cost;
          rec_d.version = rec_q.version + 32'd1;
          ok            = 1'b1;
        end
      end
      default: ;
    endcase

    out_d.ok          = ok;
    out_d.reserve_out = rec_d.reserve;
    out_d.version_out = rec_d.version;

    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        rec_q <= rec_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_create_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_cmd_i.op == cbrs_pkg::OP_CREATE && q_cmd_i.create_ok)
      |=> (rec_q.version == 32'd1 && rec_q.reserve == 16'd0))
    else $error("create did not start a fresh record");

  a_spend_version: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_cmd_i.op == cbrs_pkg::OP_SPEND && spend_ok)
      |=> (rec_q.version == $past(rec_q.version) + 32'd1))
    else $error("spend did not advance the version");

  a_fail_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && q_cmd_i.op != cbrs_pkg::OP_CREATE && !ok) |=> (rec_q == $past(rec_q)))
    else $error("failed request changed the record");

  a_reserve_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rec_q.uid != 32'd0) |-> (rec_q.reserve <= rec_q.capacity))
    else $error("reserve above capacity");

  a_result_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (out_valid_o && out_data_o.reserve_out == rec_q.reserve &&
             out_data_o.version_out == rec_q.version))
    else $error("result does not match the record");

endmodule

FILE: src/credit_bucket_regen_spend.sv
// Versioned token bucket with one credit record, an APB-style profile port and
// request/result channels. Depends on cbrs_pkg, cbrs_regs, cbrs_front, cbrs_fifo, cbrs_back.
//
// The block takes one request per cycle and returns one result per cycle when the
// result side keeps up; each request is held in the command queue and its result
// in the record unit's output register. The rate is set by the record unit, which
// settles elapsed time, the refill multiply, the caps and the spend checks ahead of
// its record register so that each request sees the record left by the one before
// it. A two-entry queue between the classifier and the record unit, and a registered
// result, let either side stall without stopping the other until the queue is full.
// Profile registers sit at byte addresses 0, 4, 8, 12 and 16 and must only be
// written while no request is in flight.
module credit_bucket_regen_spend (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cbrs_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  cbrs_pkg::cbrs_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output cbrs_pkg::cbrs_out_t           out_data_o
);

  cbrs_pkg::cbrs_prof_t prof;
  cbrs_pkg::cbrs_cmd_t  front_cmd, back_cmd;
  logic                 front_valid, front_ready;
  logic                 back_valid, back_ready;

  cbrs_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .prof_o  (prof)
  );

  cbrs_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .prof_i     (prof),
    .q_valid_o  (front_valid),
    .q_ready_i  (front_ready),
    .q_cmd_o    (front_cmd)
  );

  cbrs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (back_valid),
    .pop_ready_i  (back_ready),
    .pop_cmd_o    (back_cmd)
  );

  cbrs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prof_i      (prof),
    .q_valid_i   (back_valid),
    .q_ready_o   (back_ready),
    .q_cmd_i     (back_cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: tb/tb.sv
// Self-checking testbench for credit_bucket_regen_spend: directed requests, then random
// request traffic under several profiles, checked against an in-bench bucket predictor.
// Depends on cbrs_pkg and the credit_bucket_regen_spend RTL.
module tb;
  import cbrs_pkg::*;

  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned REQUESTS_PER_PHASE = 130;

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] prof_id;
    logic [31:0] revision;
    logic [31:0] version;
    logic [15:0] capacity;
    logic [9:0]  rate;
    logic [15:0] reserve;
    logic [31:0] settled;
  } bucket_rec_t;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_PERIODIC,
    SINK_BURSTY
  } sink_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [31:0]          pwdata;
  logic [31:0]          prdata;
  logic                 pready;
  logic                 in_valid_i;
  logic                 in_ready_o;
  cbrs_in_t             in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  cbrs_out_t            out_data_o;

  bucket_rec_t          rec_model;
  cbrs_prof_t           prof_model;
  cbrs_out_t            results_due[$];
  int unsigned          mismatch_count;
  logic [31:0]          wall_now;
  bit                   gaps_on;
  int unsigned          burst_left;

  credit_bucket_regen_spend dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit profile_valid();
    return prof_model.id != 0 && prof_model.revision != 0 && prof_model.capacity != 0 &&
           prof_model.capacity <= MANA_LIMIT && prof_model.rate <= RATE_LIMIT &&
           prof_model.floor <= prof_model.capacity;
  endfunction

  function automatic bit record_valid(input bucket_rec_t r);
    return r.uid != 0 && r.prof_id != 0 && r.revision != 0 && r.version != 0 &&
           r.capacity != 0 && r.capacity <= MANA_LIMIT && r.rate <= RATE_LIMIT &&
           r.reserve <= r.capacity;
  endfunction

  // Refills the record up to now and moves it onto the current profile.
  function automatic bit refill(inout bucket_rec_t r, input logic [31:0] stamp);
    logic [63:0] elapsed;
    logic [63:0] gain;
    logic [63:0] room;
    elapsed = '0;
    if (!record_valid(r) || !profile_valid() || r.prof_id != prof_model.id ||
        prof_model.revision < r.revision ||
        (prof_model.revision == r.revision &&
         (r.capacity != prof_model.capacity || r.rate != prof_model.rate)))
      return 1'b0;
    // A clock that went backwards regains nothing and keeps the settle time.
    if (stamp > r.settled) begin
      elapsed = 64'(stamp - r.settled);
      if (elapsed > 64'(OFFLINE_LIMIT)) elapsed = 64'(OFFLINE_LIMIT);
      r.settled = stamp;
    end
    gain = elapsed * 64'(r.rate);
    room = 64'(r.capacity - r.reserve);
    if (gain > room) gain = room;
    r.reserve = r.reserve + gain[15:0];
    if (r.reserve > prof_model.capacity) r.reserve = prof_model.capacity;
    r.capacity = prof_model.capacity;
    r.rate = prof_model.rate;
    r.revision = prof_model.revision;
    return 1'b1;
  endfunction

  function automatic cbrs_out_t predict_bucket(input cbrs_in_t req);
    bucket_rec_t nxt;
    cbrs_out_t   res;
    logic        ok;
    ok = 1'b0;
    nxt = rec_model;
    case (req.action)
      ACT_CREATE: begin
        rec_model = '0;
        if (req.new_uid != 0 && profile_valid()) begin
          rec_model.uid = req.new_uid;
          rec_model.prof_id = prof_model.id;
          rec_model.revision = prof_model.revision;
          rec_model.version = 32'd1;
          rec_model.capacity = prof_model.capacity;
          rec_model.rate = prof_model.rate;
          rec_model.settled = req.now;
          ok = 1'b1;
        end
      end
      ACT_PROJECT: begin
        if (refill(nxt, req.now)) begin
          rec_model = nxt;
          ok = 1'b1;
        end
      end
      ACT_SPEND: begin
        if (req.cost != 0 && req.cost <= MANA_LIMIT && nxt.version != '1 &&
            refill(nxt, req.now) && req.cost <= nxt.reserve &&
            !(req.passive && nxt.reserve - req.cost < prof_model.floor)) begin
          nxt.reserve = nxt.reserve - req.cost;
          nxt.version = nxt.version + 32'd1;
          rec_model = nxt;
          ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.ok = ok;
    res.reserve_out = rec_model.reserve;
    res.version_out = rec_model.version;
    return res;
  endfunction

  // ---------------------------------------------------------------- monitor

  // The result side is checked before the request side is predicted, so a result
  // can never be matched against the request taken at the same edge.
  always @(posedge clk_i) begin : check_results
    cbrs_out_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (results_due.size() == 0) begin
          $display("%0t: unexpected result ok=%0d reserve=%0d version=%0d", $time,
                   out_data_o.ok, out_data_o.reserve_out, out_data_o.version_out);
          mismatch_count++;
        end else begin
          want = results_due.pop_front();
          if (out_data_o.ok !== want.ok || out_data_o.reserve_out !== want.reserve_out ||
              out_data_o.version_out !== want.version_out) begin
            $display("%0t: bucket result wrong, expected ok=%0d reserve=%0d version=%0d,",
                     $time, want.ok, want.reserve_out, want.version_out);
            $display("    actual ok=%0d reserve=%0d version=%0d",
                     out_data_o.ok, out_data_o.reserve_out, out_data_o.version_out);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) results_due.push_back(predict_bucket(in_data_i));
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) quiet = 0;
      else quiet++;
    end
    $display("credit_bucket_regen_spend: mismatch");
    $finish;
  end

  // The result side switches at random between stall patterns, holding each for a random run.
  initial begin : result_sink
    sink_mode_e  mode;
    int unsigned run_left;
    int unsigned tick;
    out_ready_i = 1'b0;
    mode = SINK_OPEN;
    run_left = 0;
    tick = 0;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        mode = sink_mode_e'($urandom_range(0, 3));
        run_left = $urandom_range(64, 300);
      end
      run_left--;
      tick++;
      case (mode)
        SINK_OPEN:     out_ready_i <= 1'b1;
        SINK_COIN:     out_ready_i <= ($urandom_range(0, 3) != 0);
        SINK_PERIODIC: out_ready_i <= (tick % 3 != 0);
        default:       out_ready_i <= ($urandom_range(0, 15) == 0) ? ~out_ready_i : out_ready_i;
      endcase
    end
  end

  // ---------------------------------------------------------------- drivers

  // Called at a falling edge; returns at a falling edge once the request is taken.
  task automatic send_request(input logic [1:0] act, input logic [31:0] stamp,
                              input logic [31:0] uid, input logic [15:0] cost,
                              input logic passive);
    in_data_i <= '{action: act, now: stamp, new_uid: uid, cost: cost, passive: passive};
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk_i);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Drops valid and waits until every request in flight has produced its result.
  task automatic settle_requests();
    if (in_valid_i) in_valid_i <= 1'b0;
    while (results_due.size() != 0 || in_valid_i) @(negedge clk_i);
  endtask

  // Leaves psel high so that writes can follow back to back.
  task automatic write_profile_reg(input cbrs_reg_e idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    case (idx)
      REG_PROF_ID:       prof_model.id = value;
      REG_PROF_REVISION: prof_model.revision = value;
      REG_PROF_CAPACITY: prof_model.capacity = value[15:0];
      REG_PROF_RATE:     prof_model.rate = value[9:0];
      REG_PROF_FLOOR:    prof_model.floor = value[15:0];
      default: begin
      end
    endcase
    @(negedge clk_i);
  endtask

  // Unused upper bits of the narrow registers carry noise; the block must drop them.
  task automatic set_profile(input logic [31:0] id, input logic [31:0] rev,
                             input logic [15:0] cap, input logic [9:0] rate,
                             input logic [15:0] flr);
    logic [31:0] noise;
    noise = $urandom;
    write_profile_reg(REG_PROF_ID, id);
    write_profile_reg(REG_PROF_REVISION, rev);
    write_profile_reg(REG_PROF_CAPACITY, {noise[31:16], cap});
    write_profile_reg(REG_PROF_RATE, {noise[31:10], rate});
    write_profile_reg(REG_PROF_FLOOR, {noise[15:0], flr});
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_reset_record();
    gaps_on = 1'b0;
    send_request(ACT_PROJECT, 32'd10, 32'd0, 16'd0, 1'b0);
    send_request(OP_IGNORE, '1, '1, '1, 1'b1);
    send_request(ACT_CREATE, 32'd5, 32'd7, 16'd0, 1'b0);
    settle_requests();
  endtask

  task automatic test_invalid_profiles();
    set_profile(32'd0, 32'd1, 16'd10, 10'd1, 16'd0);
    send_request(ACT_CREATE, 32'd5, 32'd9, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd0, 16'd10, 10'd1, 16'd0);
    send_request(ACT_CREATE, 32'd5, 32'd9, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd1, 16'd0, 10'd1, 16'd0);
    send_request(ACT_CREATE, 32'd5, 32'd9, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd1, 16'd10, 10'd1, 16'd11);
    send_request(ACT_CREATE, 32'd5, 32'd9, 16'd0, 1'b0);
    settle_requests();
  endtask

  task automatic test_refill_and_spend();
    gaps_on = 1'b1;
    set_profile(32'd1, 32'd1, 16'd100, 10'd10, 16'd20);
    send_request(ACT_CREATE, 32'd1000, 32'd0, 16'd0, 1'b0);
    send_request(ACT_CREATE, 32'd1000, '1, 16'd0, 1'b0);
    send_request(ACT_PROJECT, 32'd1005, 32'd0, 16'd0, 1'b0);
    send_request(ACT_PROJECT, 32'd900, 32'd0, 16'd0, 1'b0);
    send_request(ACT_SPEND, 32'd1005, 32'd0, 16'd0, 1'b0);
    send_request(ACT_SPEND, 32'd1005, 32'd0, 16'd40, 1'b1);
    send_request(ACT_SPEND, 32'd1005, 32'd0, 16'd30, 1'b1);
    send_request(ACT_SPEND, 32'd1005, 32'd0, 16'd21, 1'b0);
    send_request(ACT_SPEND, 32'd1005, 32'd0, 16'd20, 1'b0);
    send_request(ACT_PROJECT, 32'd6000 + OFFLINE_LIMIT, 32'd0, 16'd0, 1'b0);
    send_request(ACT_SPEND, 32'd6000 + OFFLINE_LIMIT, 32'd0, 16'hFFFF, 1'b0);
    settle_requests();
  endtask

  task automatic test_profile_revisions();
    // A newer revision shrinks the capacity, so the reserve is clamped on adoption.
    set_profile(32'd1, 32'd2, 16'd50, 10'h3FF, 16'd0);
    send_request(ACT_PROJECT, 32'd6000 + OFFLINE_LIMIT, 32'd0, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd1, 16'd50, 10'h3FF, 16'd0);
    send_request(ACT_PROJECT, 32'd6001 + OFFLINE_LIMIT, 32'd0, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd2, 16'd60, 10'h3FF, 16'd0);
    send_request(ACT_PROJECT, 32'd6001 + OFFLINE_LIMIT, 32'd0, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd2, 32'd3, 16'd60, 10'h3FF, 16'd0);
    send_request(ACT_PROJECT, 32'd6001 + OFFLINE_LIMIT, 32'd0, 16'd0, 1'b0);
    settle_requests();
    set_profile(32'd1, 32'd3, 16'hFFFF, 10'd0, 16'hFFFF);
    send_request(ACT_SPEND, 32'd6002 + OFFLINE_LIMIT, 32'd0, 16'd1, 1'b1);
    send_request(ACT_CREATE, '1, 32'h8000_0001, 16'd0, 1'b0);
    settle_requests();
  endtask

  // Mostly well-formed request streams on a valid profile, with invalid profiles,
  // stale revisions and malformed requests mixed in.
  task automatic test_random_traffic();
    logic [31:0] id;
    logic [31:0] rev;
    logic [15:0] cap;
    logic [15:0] flr;
    logic [9:0]  rate;
    logic [15:0] cost;
    logic [31:0] uid;
    int unsigned pick;
    wall_now = 32'h0001_0000;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_requests();
      id = prof_model.id;
      rev = prof_model.revision + $urandom_range(0, 1);
      case ($urandom_range(0, 3))
        0:       cap = 16'd1;
        1:       cap = 16'hFFFF;
        2:       cap = 16'($urandom_range(1, 400));
        default: cap = 16'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(0, 3))
        0:       rate = 10'd0;
        1:       rate = 10'h3FF;
        default: rate = 10'($urandom_range(0, 1023));
      endcase
      flr = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, cap));
      case ($urandom_range(0, 9))
        0: begin
          id = $urandom;
          rev = $urandom;
        end
        1: rev = prof_model.revision - 32'd1;
        2: cap = 16'd0;
        3: begin
          if (cap != 16'hFFFF) flr = cap + 16'd1;
          else id = 32'd0;
        end
        default: begin
        end
      endcase
      set_profile(id, rev, cap, rate, flr);
      gaps_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < REQUESTS_PER_PHASE; n++) begin
        case ($urandom_range(0, 49))
          0:       wall_now = $urandom;
          1:       wall_now = wall_now - $urandom_range(1, 50);
          2:       wall_now = wall_now + $urandom_range(OFFLINE_LIMIT - 5, OFFLINE_LIMIT + 100000);
          default: wall_now = wall_now + $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 7))
          0:       cost = 16'($urandom);
          1:       cost = rec_model.reserve;
          default: cost = 16'($urandom_range(1, int'(rec_model.reserve) + 8));
        endcase
        uid = ($urandom_range(0, 9) == 0) ? 32'd0 : $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 6)
          send_request(ACT_CREATE, wall_now, uid, 16'($urandom), 1'($urandom_range(0, 1)));
        else if (pick < 40)
          send_request(ACT_PROJECT, wall_now, $urandom, 16'($urandom),
                       1'($urandom_range(0, 1)));
        else if (pick < 95)
          send_request(ACT_SPEND, wall_now, $urandom, cost, 1'($urandom_range(0, 1)));
        else if (pick < 98)
          send_request(OP_IGNORE, wall_now, $urandom, 16'($urandom),
                       1'($urandom_range(0, 1)));
        else
          send_request(ACT_SPEND, wall_now, $urandom, 16'd0, 1'($urandom_range(0, 1)));
      end
    end
    settle_requests();
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    rec_model = '0;
    prof_model = '0;
    mismatch_count = 0;
    wall_now = '0;
    gaps_on = 1'b0;
    burst_left = 0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_record();
    test_invalid_profiles();
    test_refill_and_spend();
    test_profile_revisions();
    test_random_traffic();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0 && results_due.size() == 0)
      $display("credit_bucket_regen_spend: match");
    else
      $display("credit_bucket_regen_spend: mismatch");
    $finish;
  end

endmodule

FILE: credit_bucket_regen_spend.f
src/cbrs_pkg.sv
src/cbrs_regs.sv
src/cbrs_front.sv
src/cbrs_fifo.sv
src/cbrs_back.sv
src/credit_bucket_regen_spend.sv
tb/tb.sv
